@@ sv/fat12_cluster_chain_walker_macros.svh @@
// Assertion macros used by the FAT12 cluster chain walker RTL.
// Needs a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef FAT12_CLUSTER_CHAIN_WALKER_MACROS_SVH
`define FAT12_CLUSTER_CHAIN_WALKER_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define FCCW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define FCCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/fccw_pkg.sv @@
// Shared types and constants of the FAT12 cluster chain walker.
// Used by every module of the block; depends on nothing else.
package fccw_pkg;

  // Size of the FAT byte store and its address width.
  localparam int unsigned FAT_BYTES = 8192;
  localparam int unsigned FAT_AW    = $clog2(FAT_BYTES);

  // Field widths fixed by the interface.
  localparam int unsigned CLUSTER_W  = 12;
  localparam int unsigned BYTE_ADDR_W = 13;
  localparam int unsigned OFFSET_W   = 13;
  localparam int unsigned SECTOR_W   = 16;
  localparam int unsigned SPC_W      = 8;
  localparam int unsigned BPS_W      = 13;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Entries at or above this value end a chain.
  localparam logic [CLUSTER_W-1:0] END_MARK = 12'hFF8;
  // Cluster number of the first data cluster.
  localparam logic [SECTOR_W-1:0] FIRST_DATA_CLUSTER = 16'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SPC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BPS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DSS = 2'd2;

  // Configuration reset values.
  localparam logic [SPC_W-1:0]    SPC_RESET = 8'd1;
  localparam logic [BPS_W-1:0]    BPS_RESET = 13'd512;
  localparam logic [SECTOR_W-1:0] DSS_RESET = 16'd33;

  typedef enum logic [1:0] {
    MODE_WRITE   = 2'd0,
    MODE_START   = 2'd1,
    MODE_ADVANCE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD_HI,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [SPC_W-1:0]    spc;
    logic [BPS_W-1:0]    bps;
    logic [SECTOR_W-1:0] dss;
  } cfg_t;

endpackage

@@ sv/fccw_fat_ram.sv @@
// FAT byte store: one write port and one read port with registered read data.
// Depends on fccw_pkg for the store size.
module fccw_fat_ram
  import fccw_pkg::*;
(
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [FAT_AW-1:0] waddr_i,
  input  logic [7:0]        wdata_i,
  input  logic [FAT_AW-1:0] raddr_i,
  output logic [7:0]        rdata_o
);

  logic [7:0] mem [FAT_BYTES];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/fccw_addr_calc.sv @@
// Sector address and destination step arithmetic for one cluster.
// Depends on fccw_pkg for widths and the configuration struct.
module fccw_addr_calc
  import fccw_pkg::*;
(
  input  cfg_t                 cfg_i,
  input  logic [CLUSTER_W-1:0] cluster_i,
  input  logic [ADDR_W-1:0]    dest_i,
  output logic [SECTOR_W-1:0]  sector_o,
  output logic [ADDR_W-1:0]    dest_next_o
);

  logic [SECTOR_W-1:0]      rel_cluster;
  logic [SECTOR_W+SPC_W-1:0] sector_prod;
  logic [BPS_W+SPC_W-1:0]   cluster_bytes;

  // Clusters below two wrap; only the low 16 bits of the product matter.
  assign rel_cluster   = SECTOR_W'(cluster_i) - FIRST_DATA_CLUSTER;
  assign sector_prod   = rel_cluster * cfg_i.spc;
  assign sector_o      = cfg_i.dss + sector_prod[SECTOR_W-1:0];

  assign cluster_bytes = cfg_i.bps * cfg_i.spc;
  assign dest_next_o   = dest_i + ADDR_W'(cluster_bytes);

endmodule

@@ sv/fccw_ctrl.sv @@
// Sequencer of the chain walker: item decode, FAT reads and result registers.
// Depends on fccw_pkg, fccw_addr_calc results and the assertion macro header.
`include "fat12_cluster_chain_walker_macros.svh"

module fccw_ctrl
  import fccw_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [1:0]             mode_i,
  input  logic [BYTE_ADDR_W-1:0] fat_byte_addr_i,
  input  logic [7:0]             fat_byte_value_i,
  input  logic [CLUSTER_W-1:0]   start_cluster_i,
  input  logic [ADDR_W-1:0]      dest_base_i,
  input  cfg_t                   cfg_i,
  output logic [CLUSTER_W-1:0]   cluster_o,
  output logic [ADDR_W-1:0]      dest_o,
  input  logic [SECTOR_W-1:0]    sector_i,
  input  logic [ADDR_W-1:0]      dest_next_i,
  output logic                   ram_we_o,
  output logic [FAT_AW-1:0]      ram_waddr_o,
  output logic [7:0]             ram_wdata_o,
  output logic [FAT_AW-1:0]      ram_raddr_o,
  input  logic [7:0]             ram_rdata_i,
  output logic                   done_o,
  output logic [SECTOR_W-1:0]    read_sector_o,
  output logic [SPC_W-1:0]       read_count_o,
  output logic [ADDR_W-1:0]      read_dest_o,
  output logic [CLUSTER_W-1:0]   chain_cluster_o,
  output logic                   last_o,
  output logic                   status_o
);

  state_e state_q, state_d;

  logic                 active_q, active_d;
  logic [CLUSTER_W-1:0] cur_q, cur_d;
  logic [ADDR_W-1:0]    dest_q, dest_d;
  logic [7:0]           lo_q;

  logic                 done_q, done_d;
  logic [SECTOR_W-1:0]  sector_q;
  logic [SPC_W-1:0]     count_q;
  logic [ADDR_W-1:0]    rdest_q;
  logic [CLUSTER_W-1:0] clus_q;
  logic                 last_q;
  logic                 status_q;
  logic                 load_cmd, load_err;

  logic                 accept;
  logic [OFFSET_W-1:0]  offset;
  logic [15:0]          pair;
  logic [CLUSTER_W-1:0] fat_entry;
  logic                 is_last;
  logic                 addr_ok;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);

  // Byte offset of a 12-bit entry is one and a half times the cluster number.
  assign offset = OFFSET_W'(cur_q) + OFFSET_W'(cur_q[CLUSTER_W-1:1]);

  // Little-endian byte pair; odd clusters use the upper twelve bits.
  assign pair      = {ram_rdata_i, lo_q};
  assign fat_entry = cur_q[0] ? pair[15:4] : pair[11:0];
  assign is_last   = (fat_entry >= END_MARK);

  assign addr_ok = (32'(fat_byte_addr_i) < FAT_BYTES);

  assign ram_waddr_o = FAT_AW'(fat_byte_addr_i);
  assign ram_wdata_o = fat_byte_value_i;
  assign ram_raddr_o = (state_q == ST_IDLE) ? FAT_AW'(offset) : FAT_AW'(offset + 1'b1);

  assign cluster_o = cur_q;
  assign dest_o    = dest_q;

  always_comb begin
    state_d  = state_q;
    active_d = active_q;
    cur_d    = cur_q;
    dest_d   = dest_q;
    ram_we_o = 1'b0;
    load_cmd = 1'b0;
    load_err = 1'b0;
    done_d   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (mode_i)
            MODE_WRITE: begin
              ram_we_o = addr_ok;
            end
            MODE_START: begin
              cur_d    = start_cluster_i;
              dest_d   = dest_base_i;
              active_d = 1'b1;
            end
            MODE_ADVANCE: begin
              if (active_q) begin
                state_d = ST_RD_HI;
              end else begin
                load_err = 1'b1;
                done_d   = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_RD_HI: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        load_cmd = 1'b1;
        done_d   = 1'b1;
        cur_d    = fat_entry;
        dest_d   = dest_next_i;
        active_d = !is_last;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      active_q <= 1'b0;
      cur_q    <= '0;
      dest_q   <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      active_q <= active_d;
      cur_q    <= cur_d;
      dest_q   <= dest_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_RD_HI) begin
      lo_q <= ram_rdata_i;
    end
    if (load_cmd) begin
      sector_q <= sector_i;
      count_q  <= cfg_i.spc;
      rdest_q  <= dest_q;
      clus_q   <= cur_q;
      last_q   <= is_last;
      status_q <= 1'b0;
    end else if (load_err) begin
      sector_q <= '0;
      count_q  <= '0;
      rdest_q  <= '0;
      clus_q   <= '0;
      last_q   <= 1'b0;
      status_q <= 1'b1;
    end
  end

  assign done_o          = done_q;
  assign read_sector_o   = sector_q;
  assign read_count_o    = count_q;
  assign read_dest_o     = rdest_q;
  assign chain_cluster_o = clus_q;
  assign last_o          = last_q;
  assign status_o        = status_q;

  `FCCW_ASSERT_NEXT(a_hi_then_fin, state_q == ST_RD_HI, state_q == ST_FIN, "second FAT read not followed by finish")
  `FCCW_ASSERT_NEXT(a_fin_active, state_q == ST_FIN, (active_q == !last_q) && done_q && !status_q, "chain state disagrees with last flag")
  `FCCW_ASSERT_NOW(a_write_idle, ram_we_o, state_q == ST_IDLE, "FAT write while a read is in flight")
  `FCCW_ASSERT_NEXT(a_err_result, load_err, done_q && status_q && (state_q == ST_IDLE), "no error result for advance without chain")

endmodule

@@ sv/fat12_cluster_chain_walker.sv @@
// Top level of the FAT12 cluster chain walker: configuration registers and wiring.
// Depends on fccw_pkg, fccw_fat_ram, fccw_addr_calc and fccw_ctrl.

// An item transfers at a rising edge where start is high and busy is low. A
// FAT byte write, a chain start and an ignored mode leave busy low, and the
// next item may follow at once. An advance on an active chain reads the two
// bytes of the 12-bit entry through the single registered read port of the FAT
// store and then loads the result register: busy is high while the sequencer
// is in ST_RD_HI and ST_FIN, and done_o is high for exactly one cycle, the
// cycle after ST_FIN, at whose end the next item can transfer. An advance with
// no active chain answers with status_o set, done_o high in the cycle after
// the accepting edge. The receiver cannot stall: each result transfer happens
// in the one cycle that done_o is high, so the result ports must be captured
// then; they hold until the next result. A new item may be accepted while a
// result is on the ports. The FAT store is not cleared after reset, so an
// entry must be written before a chain reads it. Configuration writes take
// effect at once and are meant only while idle.
module fat12_cluster_chain_walker
  import fccw_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             mode_i,
  input  logic [BYTE_ADDR_W-1:0] fat_byte_addr_i,
  input  logic [7:0]             fat_byte_value_i,
  input  logic [CLUSTER_W-1:0]   start_cluster_i,
  input  logic [ADDR_W-1:0]      dest_base_i,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output logic                   done_o,
  output logic [SECTOR_W-1:0]    read_sector_o,
  output logic [SPC_W-1:0]       read_count_o,
  output logic [ADDR_W-1:0]      read_dest_o,
  output logic [CLUSTER_W-1:0]   chain_cluster_o,
  output logic                   last_o,
  output logic                   status_o
);

  cfg_t cfg_q;

  logic [CLUSTER_W-1:0] cluster;
  logic [ADDR_W-1:0]    dest;
  logic [SECTOR_W-1:0]  sector;
  logic [ADDR_W-1:0]    dest_next;
  logic                 ram_we;
  logic [FAT_AW-1:0]    ram_waddr;
  logic [7:0]           ram_wdata;
  logic [FAT_AW-1:0]    ram_raddr;
  logic [7:0]           ram_rdata;

  // Register writes; an index beyond the three registers is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.spc <= SPC_RESET;
      cfg_q.bps <= BPS_RESET;
      cfg_q.dss <= DSS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SPC: cfg_q.spc <= cfg_data_i[SPC_W-1:0];
        CFG_BPS: cfg_q.bps <= cfg_data_i[BPS_W-1:0];
        CFG_DSS: cfg_q.dss <= cfg_data_i[SECTOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sector address and next destination of the current cluster.
  fccw_addr_calc u_calc (
    .cfg_i       (cfg_q),
    .cluster_i   (cluster),
    .dest_i      (dest),
    .sector_o    (sector),
    .dest_next_o (dest_next)
  );

  // The FAT byte store, read one byte per cycle.
  fccw_fat_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Item sequencer and result registers.
  fccw_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_o           (busy),
    .mode_i           (mode_i),
    .fat_byte_addr_i  (fat_byte_addr_i),
    .fat_byte_value_i (fat_byte_value_i),
    .start_cluster_i  (start_cluster_i),
    .dest_base_i      (dest_base_i),
    .cfg_i            (cfg_q),
    .cluster_o        (cluster),
    .dest_o           (dest),
    .sector_i         (sector),
    .dest_next_i      (dest_next),
    .ram_we_o         (ram_we),
    .ram_waddr_o      (ram_waddr),
    .ram_wdata_o      (ram_wdata),
    .ram_raddr_o      (ram_raddr),
    .ram_rdata_i      (ram_rdata),
    .done_o           (done_o),
    .read_sector_o    (read_sector_o),
    .read_count_o     (read_count_o),
    .read_dest_o      (read_dest_o),
    .chain_cluster_o  (chain_cluster_o),
    .last_o           (last_o),
    .status_o         (status_o)
  );

endmodule
